>>> src/hce_pkg.sv
// Shared types and constants for the Hack instruction execute block.
`timescale 1ns / 1ps

package hce_pkg;

	// Widths of a data word and of an address
	localparam int unsigned WORD_W = 16;
	localparam int unsigned ADDR_W = 15;

	// Top three bits of a compute instruction
	localparam logic [2:0] TOP_COMPUTE = 3'b111;

	// Comp field codes
	localparam logic [5:0] COMP_ZERO   = 6'd42;
	localparam logic [5:0] COMP_ONE    = 6'd63;
	localparam logic [5:0] COMP_MINUS1 = 6'd58;
	localparam logic [5:0] COMP_D      = 6'd12;
	localparam logic [5:0] COMP_Y      = 6'd48;
	localparam logic [5:0] COMP_NOT_D  = 6'd13;
	localparam logic [5:0] COMP_NOT_Y  = 6'd49;
	localparam logic [5:0] COMP_NEG_D  = 6'd15;
	localparam logic [5:0] COMP_NEG_Y  = 6'd51;
	localparam logic [5:0] COMP_D_INC  = 6'd31;
	localparam logic [5:0] COMP_Y_INC  = 6'd55;
	localparam logic [5:0] COMP_D_DEC  = 6'd14;
	localparam logic [5:0] COMP_Y_DEC  = 6'd50;
	localparam logic [5:0] COMP_D_ADD_Y = 6'd2;
	localparam logic [5:0] COMP_D_SUB_Y = 6'd19;
	localparam logic [5:0] COMP_Y_SUB_D = 6'd7;
	localparam logic [5:0] COMP_D_AND_Y = 6'd0;
	localparam logic [5:0] COMP_D_OR_Y  = 6'd21;

	// Condition flags of an ALU result
	typedef struct packed {
		logic neg;
		logic zero;
	} alu_flags_t;

endpackage

>>> src/hce_alu.sv
// Hack ALU: comp-code function of D and Y, with sign and zero flags.
`timescale 1ns / 1ps

module hce_alu
	import hce_pkg::*;
(
	input  logic [5:0]        comp,
	input  logic [WORD_W-1:0] d,
	input  logic [WORD_W-1:0] y,
	output logic [WORD_W-1:0] result,
	output alu_flags_t        flags
);

	// Select the function; codes outside the set give zero
	always_comb begin
		case (comp)
			COMP_ZERO:    result = '0;
			COMP_ONE:     result = 16'd1;
			COMP_MINUS1:  result = '1;
			COMP_D:       result = d;
			COMP_Y:       result = y;
			COMP_NOT_D:   result = ~d;
			COMP_NOT_Y:   result = ~y;
			COMP_NEG_D:   result = 16'd0 - d;
			COMP_NEG_Y:   result = 16'd0 - y;
			COMP_D_INC:   result = d + 16'd1;
			COMP_Y_INC:   result = y + 16'd1;
			COMP_D_DEC:   result = d - 16'd1;
			COMP_Y_DEC:   result = y - 16'd1;
			COMP_D_ADD_Y: result = d + y;
			COMP_D_SUB_Y: result = d - y;
			COMP_Y_SUB_D: result = y - d;
			COMP_D_AND_Y: result = d & y;
			COMP_D_OR_Y:  result = d | y;
			default:      result = '0;
		endcase
	end

	// Flags for the jump conditions
	assign flags.neg  = result[WORD_W-1];
	assign flags.zero = (result == '0);

endmodule

>>> src/hack_cpu_execute.sv
// Top level of the Hack instruction execute block.
//
// Usage:
//   The slave channel takes one instruction per transaction together with the
//   data memory word at the current A address. The master channel returns one
//   result per instruction: the store request (enable, address, data), the
//   next operand address, the next program counter and register D; tuser flags
//   an instruction whose top bits are 100, 101 or 110 (nothing executed).
//   A transaction passes through the input register, then the result register.
//   Throughput: one instruction per cycle while the receiver does not stall;
//   registers A, D and PC update in the same cycle as the ALU evaluates, so
//   each instruction sees the previous one.
//   Reset clears A, D, PC and both valid flags; no transaction is pending.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; s_axis_tready then drops until the result is
//   taken, and no transaction is lost.
`timescale 1ns / 1ps

module hack_cpu_execute
	import hce_pkg::*;
#(
	parameter int ROM_ADDR_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // instruction[15:0], mem_data[31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // write_enable[0], write_address[15:1],
	                                    // write_data[31:16], read_address[46:32],
	                                    // next_pc[61:47], d_value[77:62], zero[79:78]
	output logic [0:0]  m_axis_tuser    // illegal[0]
);

	// Input stage
	logic              valid_s1;
	logic [WORD_W-1:0] instr_s1;
	logic [WORD_W-1:0] mem_s1;

	// Architectural state
	logic [WORD_W-1:0]        a_q;
	logic [WORD_W-1:0]        d_q;
	logic [ROM_ADDR_BITS-1:0] pc_q;

	// Result register
	logic              out_valid_q;
	logic              we_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [WORD_W-1:0] wdata_q;
	logic [ADDR_W-1:0] raddr_q;
	logic [ADDR_W-1:0] npc_q;
	logic [WORD_W-1:0] dval_q;
	logic              illegal_q;

	logic advance;

	// Decode
	logic              is_addr;
	logic              is_comp;
	logic [WORD_W-1:0] y_op;
	logic [WORD_W-1:0] alu_res;
	alu_flags_t        flags;
	logic              take;

	logic [WORD_W-1:0]        a_nx;
	logic [WORD_W-1:0]        d_nx;
	logic [ROM_ADDR_BITS-1:0] pc_nx;
	logic                     we_nx;
	logic [WORD_W-1:0]        wdata_nx;
	logic [WORD_W-1:0]        pc_ext;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Capture the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			instr_s1 <= s_axis_tdata[15:0];
			mem_s1   <= s_axis_tdata[31:16];
		end
	end

	assign is_addr = !instr_s1[15];
	assign is_comp = (instr_s1[15:13] == TOP_COMPUTE);
	assign y_op    = instr_s1[12] ? mem_s1 : a_q;

	hce_alu u_alu (
		.comp   (instr_s1[11:6]),
		.d      (d_q),
		.y      (y_op),
		.result (alu_res),
		.flags  (flags)
	);

	assign take = (instr_s1[2] && flags.neg) || (instr_s1[1] && flags.zero) ||
	              (instr_s1[0] && !flags.neg && !flags.zero);

	// Next state of A, D and PC
	always_comb begin
		a_nx     = a_q;
		d_nx     = d_q;
		pc_nx    = pc_q;
		we_nx    = 1'b0;
		wdata_nx = '0;
		if (is_addr) begin
			a_nx  = {1'b0, instr_s1[14:0]};
			pc_nx = pc_q + 1'b1;
		end else if (is_comp) begin
			wdata_nx = alu_res;
			we_nx    = instr_s1[3];
			if (instr_s1[4]) begin
				d_nx = alu_res;
			end
			if (instr_s1[5]) begin
				a_nx = alu_res;
			end
			if (take) begin
				pc_nx = a_q[ROM_ADDR_BITS-1:0];
			end else begin
				pc_nx = pc_q + 1'b1;
			end
		end
	end

	assign pc_ext = WORD_W'(pc_nx);

	// Commit state and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= '0;
			d_q         <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			a_q         <= a_nx;
			d_q         <= d_nx;
			pc_q        <= pc_nx;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			we_q      <= we_nx;
			waddr_q   <= a_q[ADDR_W-1:0];
			wdata_q   <= wdata_nx;
			raddr_q   <= a_nx[ADDR_W-1:0];
			npc_q     <= pc_ext[ADDR_W-1:0];
			dval_q    <= d_nx;
			illegal_q <= !is_addr && !is_comp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, dval_q, npc_q, raddr_q, wdata_q, waddr_q, we_q};
	assign m_axis_tuser  = illegal_q;

endmodule

>>> src/hce_checker.sv
// Port-level checks for the Hack instruction execute block, bound to the top.
`timescale 1ns / 1ps

module hce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// Illegal instruction makes no store
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
			(!m_axis_tdata[0] && m_axis_tdata[31:16] == 16'd0))
	else $error("illegal instruction produced a store");

	// Illegal instruction leaves A unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
			(m_axis_tdata[46:32] == m_axis_tdata[15:1]))
	else $error("illegal instruction changed A");

	// Hold a stalled transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
	else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			($stable(m_axis_tdata) && $stable(m_axis_tuser)))
	else $error("result changed while stalled");

endmodule

bind hack_cpu_execute hce_checker u_hce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/hack_cpu_execute_tb.sv
// Self-checking testbench for the Hack instruction execute block.
`timescale 1ns / 1ps

module hack_cpu_execute_tb;
	import hce_pkg::*;

	localparam int PC_W = 15;

	// Top bits of the non-compute instruction classes
	localparam logic [2:0] TOP_BAD_100 = 3'b100;
	localparam logic [2:0] TOP_BAD_101 = 3'b101;
	localparam logic [2:0] TOP_BAD_110 = 3'b110;
	// A comp code outside the defined set
	localparam logic [5:0] COMP_UNDEFINED = 6'd1;

	typedef struct packed {
		logic [2:0] top;
		logic       a;
		logic [5:0] comp;
		logic [2:0] dest;   // dest[2] A, dest[1] D, dest[0] M
		logic [2:0] jump;   // jump[2] neg, jump[1] zero, jump[0] pos
	} instr_fields_t;

	typedef struct packed {
		logic        we;
		logic [14:0] waddr;
		logic [15:0] wdata;
		logic [14:0] raddr;
		logic [14:0] pc;
		logic [15:0] d;
		logic        illegal;
	} exec_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // instruction[15:0], mem_data[31:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // write_enable[0], write_address[15:1], write_data[31:16],
	                             // read_address[46:32], next_pc[61:47], d_value[77:62]
	logic [0:0]  m_axis_tuser;   // illegal[0]

	// Predicted architectural state
	logic [15:0]     reg_a;
	logic [15:0]     reg_d;
	logic [PC_W-1:0] reg_pc;

	exec_result_t result_q[$];
	bit           no_gaps;
	int           hold_cycles;
	int           err_count;
	int           n_issued;
	int           n_checked;
	int           n_illegal;
	int           n_taken;
	int           n_stores;

	hack_cpu_execute #(
		.ROM_ADDR_BITS(PC_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// ALU function table; undefined codes give zero
	function automatic logic [15:0] alu_eval(logic [5:0] comp, logic [15:0] d, logic [15:0] y);
		case (comp)
			COMP_ZERO:    return 16'h0000;
			COMP_ONE:     return 16'h0001;
			COMP_MINUS1:  return 16'hFFFF;
			COMP_D:       return d;
			COMP_Y:       return y;
			COMP_NOT_D:   return ~d;
			COMP_NOT_Y:   return ~y;
			COMP_NEG_D:   return 16'h0000 - d;
			COMP_NEG_Y:   return 16'h0000 - y;
			COMP_D_INC:   return d + 16'h0001;
			COMP_Y_INC:   return y + 16'h0001;
			COMP_D_DEC:   return d - 16'h0001;
			COMP_Y_DEC:   return y - 16'h0001;
			COMP_D_ADD_Y: return d + y;
			COMP_D_SUB_Y: return d - y;
			COMP_Y_SUB_D: return y - d;
			COMP_D_AND_Y: return d & y;
			COMP_D_OR_Y:  return d | y;
			default:      return 16'h0000;
		endcase
	endfunction

	function automatic logic [5:0] comp_code(int idx);
		case (idx)
			0:       return COMP_ZERO;
			1:       return COMP_ONE;
			2:       return COMP_MINUS1;
			3:       return COMP_D;
			4:       return COMP_Y;
			5:       return COMP_NOT_D;
			6:       return COMP_NOT_Y;
			7:       return COMP_NEG_D;
			8:       return COMP_NEG_Y;
			9:       return COMP_D_INC;
			10:      return COMP_Y_INC;
			11:      return COMP_D_DEC;
			12:      return COMP_Y_DEC;
			13:      return COMP_D_ADD_Y;
			14:      return COMP_D_SUB_Y;
			15:      return COMP_Y_SUB_D;
			16:      return COMP_D_AND_Y;
			default: return COMP_D_OR_Y;
		endcase
	endfunction

	function automatic logic [15:0] mem_extreme(int idx);
		case (idx % 5)
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			3:       return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [15:0] c_instr(logic a, logic [5:0] comp, logic [2:0] dest,
			logic [2:0] jump);
		instr_fields_t f;
		f.top = TOP_COMPUTE;
		f.a = a;
		f.comp = comp;
		f.dest = dest;
		f.jump = jump;
		return f;
	endfunction

	// Execute one instruction on the predicted state and return the expected result
	function automatic exec_result_t execute_predict(logic [15:0] ins, logic [15:0] mem);
		exec_result_t  res;
		instr_fields_t f;
		logic [15:0]   old_a;
		logic [15:0]   y;
		logic [15:0]   r;
		logic          take;
		f = ins;
		old_a = reg_a;
		res = '0;
		res.waddr = old_a[14:0];
		if (!f.top[2]) begin
			reg_a = {1'b0, ins[14:0]};
			reg_pc = reg_pc + 1'b1;
		end else if (f.top == TOP_COMPUTE) begin
			y = f.a ? mem : old_a;
			r = alu_eval(f.comp, reg_d, y);
			take = (f.jump[2] && r[15]) || (f.jump[1] && r == 16'h0000) ||
			       (f.jump[0] && !r[15] && r != 16'h0000);
			res.wdata = r;
			res.we = f.dest[0];
			if (f.dest[1])
				reg_d = r;
			if (f.dest[2])
				reg_a = r;
			reg_pc = take ? old_a[PC_W-1:0] : reg_pc + 1'b1;
			n_taken += take;
			n_stores += f.dest[0];
		end else begin
			res.illegal = 1'b1;
			n_illegal++;
		end
		res.raddr = reg_a[14:0];
		res.pc = 15'(reg_pc);
		res.d = reg_d;
		return res;
	endfunction

	// Offer one instruction, with random idle cycles before it unless no_gaps is set, and log its prediction
	task automatic send_instr(logic [15:0] ins, logic [15:0] mem);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {mem, ins};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		result_q.push_back(execute_predict(ins, mem));
		n_issued++;
	endtask

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %h, got %h", name, exp_val, act_val);
			err_count++;
		end
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		exec_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				$error("result transaction with no instruction pending");
				err_count++;
			end else begin
				exp_res = result_q.pop_front();
				check_field("write_enable", 16'(exp_res.we), 16'(m_axis_tdata[0]));
				check_field("write_address", 16'(exp_res.waddr), 16'(m_axis_tdata[15:1]));
				check_field("write_data", exp_res.wdata, m_axis_tdata[31:16]);
				check_field("read_address", 16'(exp_res.raddr), 16'(m_axis_tdata[46:32]));
				check_field("next_pc", 16'(exp_res.pc), 16'(m_axis_tdata[61:47]));
				check_field("d_value", exp_res.d, m_axis_tdata[77:62]);
				check_field("illegal", 16'(exp_res.illegal), 16'(m_axis_tuser[0]));
				n_checked++;
			end
		end
	end

	// Result receiver: random stalls, always ready under no_gaps, or a counted hold-off when requested
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 31);
			end
		end
	end

	task automatic test_address_loads();
		send_instr(16'h7FFF, 16'h8000);
		send_instr(16'h0000, 16'h7FFF);
	endtask

	// Every ALU function once, walking through all dest and jump codes
	task automatic test_alu_functions();
		int i;
		for (i = 0; i < 18; i++)
			send_instr(c_instr(i[0], comp_code(i), 3'(i), 3'(i * 3)), mem_extreme(i));
	endtask

	task automatic test_special_cases();
		send_instr(c_instr(1'b1, COMP_UNDEFINED, 3'b111, 3'b010), 16'h1234);
		send_instr({TOP_BAD_100, 13'h1FFF}, 16'hFFFF);
		send_instr({TOP_BAD_101, 13'h0000}, 16'h0000);
		send_instr({TOP_BAD_110, 13'h0ABC}, 16'h8000);
		// Jump to the top of the address space, then let the PC wrap to zero
		send_instr(16'h7FFF, 16'h0000);
		send_instr(c_instr(1'b0, COMP_ZERO, 3'b000, 3'b111), 16'h0000);
		send_instr(16'h0005, 16'h0000);
	endtask

	task automatic send_random(int count);
		int          i;
		int          pick;
		logic [15:0] ins;
		logic [15:0] mem;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				ins = {1'b0, 15'($urandom)};
			else if (pick < 85)
				ins = c_instr(1'($urandom), comp_code($urandom_range(0, 17)),
				              3'($urandom), 3'($urandom));
			else if (pick < 90)
				ins = c_instr(1'($urandom), 6'($urandom), 3'($urandom), 3'($urandom));
			else if (pick < 95)
				ins = {3'($urandom_range(TOP_BAD_100, TOP_BAD_110)), 13'($urandom)};
			else
				ins = 16'($urandom);
			mem = ($urandom_range(0, 99) < 20) ? mem_extreme($urandom_range(0, 4))
			                                    : 16'($urandom);
			send_instr(ins, mem);
		end
	endtask

	task automatic test_random_programs();
		send_random(380);
	endtask

	task automatic test_full_rate();
		no_gaps = 1'b1;
		send_random(60);
		no_gaps = 1'b0;
	endtask

	// Stall the receiver long enough for the block to fill and drop tready
	task automatic test_backpressure();
		hold_cycles = 80;
		send_random(30);
	endtask

	initial begin
		int guard;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		reg_a = '0;
		reg_d = '0;
		reg_pc = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_address_loads();
		test_alu_functions();
		test_special_cases();
		test_random_programs();
		test_full_rate();
		test_backpressure();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain outstanding results, then watch for stray transactions
		guard = 0;
		while (result_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d results never arrived", result_q.size());
			err_count++;
		end

		$display("Ran %0d instructions: %0d illegal, %0d taken jumps, %0d stores.",
		         n_issued, n_illegal, n_taken, n_stores);
		$display("Checked %0d results over directed, random, full-rate and stall phases.",
		         n_checked);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
src/hce_pkg.sv
src/hce_alu.sv
src/hack_cpu_execute.sv
src/hce_checker.sv
tb/hack_cpu_execute_tb.sv
